[hdl/ttl_pkg.sv]
package ttl_pkg;

  localparam int CODE_W    = 10;
  localparam int VCC_W     = 13;
  localparam int SER_W     = 20;
  localparam int COEF_W    = 48;
  localparam int TEMP_W    = 24;
  localparam int VOLT_W    = 13;
  localparam int STAT_W    = 2;
  localparam int REG_IDX_W = 3;

  localparam int ADC_FULL_SCALE_DEF = 1023;
  localparam int COEF_FRAC_BITS_DEF = 46;

  localparam int RAIL_LOW_MV  = 10;
  localparam int RAIL_HIGH_MV = 3280;

  // log2 datapath, sized for the widest full scale
  localparam int FS_W_MAX  = 16;
  localparam int NUM_W     = SER_W + FS_W_MAX;
  localparam int KW        = $clog2(NUM_W);
  localparam int NORM_FRAC = 30;
  localparam int LOG_STEPS = 26;
  localparam int LOG_W     = KW + LOG_STEPS;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // polynomial widths
  localparam int L_W    = LOG_W - 1;
  localparam int P2_W   = 2 * L_W - 24;
  localparam int P3_W   = P2_W + L_W - 24;
  localparam int CH_W   = COEF_W - 24;
  localparam int CL_W   = 24;
  localparam int TERM_W = CH_W + P3_W + 1;
  localparam int D_W    = TERM_W + 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_RAIL = 2'd1,
    STAT_DEN  = 2'd2
  } stat_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VCC    = 3'd0,
    REG_SERIES = 3'd1,
    REG_COEF_A = 3'd2,
    REG_COEF_B = 3'd3,
    REG_COEF_C = 3'd4,
    REG_COEF_D = 3'd5
  } reg_e;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic              rail;
  } side_t;

  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] d;
  } coef_t;

  function automatic logic [KW-1:0] msb_pos(input logic [NUM_W-1:0] x);
    logic [KW-1:0] p;
    p = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (x[i]) p = KW'(i);
    end
    return p;
  endfunction

endpackage

[hdl/thermistor_temperature_linearizer.sv]
// Thermistor linearizer: 10-bit converter samples in, temperature out.
// Input beats on s_axis carry one adc_code each; output beats on m_axis carry
// temperature_q8, volts_mv and a status code (ok, rail fault, bad denominator).
// The cfg channel writes vcc_mv, series_ohms and the four Q1.46 coefficients
// by index; it is always ready and must only be used while no sample is in
// flight. Writes to unknown indexes are dropped.
// A sample passes through 4 front stages (scaling, rail check, resistance,
// normalize), 26 log2 squaring stages, 9 polynomial stages and 25 divider
// stages (one quotient bit per inner stage). Throughput is one sample per
// cycle unless the output stalls; every stage is a fixed-latency step, so the
// log2 multipliers and the per-bit divider set the depth, not the rate.
// The whole pipeline advances together: when the receiver holds tready low
// with a result waiting, every stage holds and s_axis_tready_o drops, so no
// beat is lost or repeated. An empty output register keeps the pipe moving.
// Reset clears all valid bits and loads vcc_mv 3300, series_ohms 10000 and
// zero coefficients.
module thermistor_temperature_linearizer import ttl_pkg::*; #(
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [15:0]          s_axis_tdata_i,   // [9:0] adc_code
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [39:0]          m_axis_tdata_o,   // [23:0] temperature_q8, [36:24] volts_mv
  output logic [STAT_W-1:0]    m_axis_tuser_o,   // [1:0] status
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  logic [VCC_W-1:0] vcc_q;
  logic [SER_W-1:0] series_q;
  coef_t            coef_q;

  logic               en;
  logic               f_vld, l_vld, p_vld;
  side_t              f_side, l_side, p_side;
  logic [NORM_FRAC:0] f_y [2];
  logic [KW-1:0]      f_k [2];
  logic [LOG_W-1:0]   l_log [2];
  logic signed [D_W-1:0] p_den;
  logic [TEMP_W-1:0]  temp;
  logic [VOLT_W-1:0]  volts;
  stat_e              stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcc_q    <= VCC_W'(3300);
      series_q <= SER_W'(10000);
      coef_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VCC:    vcc_q    <= cfg_data_i[VCC_W-1:0];
        REG_SERIES: series_q <= cfg_data_i[SER_W-1:0];
        REG_COEF_A: coef_q.a <= cfg_data_i;
        REG_COEF_B: coef_q.b <= cfg_data_i;
        REG_COEF_C: coef_q.c <= cfg_data_i;
        REG_COEF_D: coef_q.d <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ttl_front #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid_i),
    .code_i   (s_axis_tdata_i[CODE_W-1:0]),
    .vcc_i    (vcc_q),
    .series_i (series_q),
    .vld_o    (f_vld),
    .side_o   (f_side),
    .ynum_o   (f_y[0]),
    .knum_o   (f_k[0]),
    .ycode_o  (f_y[1]),
    .kcode_o  (f_k[1])
  );

  ttl_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .side_i (f_side),
    .y_i    (f_y),
    .k_i    (f_k),
    .vld_o  (l_vld),
    .side_o (l_side),
    .log_o  (l_log)
  );

  ttl_poly u_poly (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (l_vld),
    .side_i    (l_side),
    .lognum_i  (l_log[0]),
    .logcode_i (l_log[1]),
    .coef_i    (coef_q),
    .vld_o     (p_vld),
    .side_o    (p_side),
    .den_o     (p_den)
  );

  ttl_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (p_vld),
    .side_i  (p_side),
    .den_i   (p_den),
    .vld_o   (m_axis_tvalid_o),
    .temp_o  (temp),
    .volts_o (volts),
    .stat_o  (stat)
  );

  assign m_axis_tdata_o = {3'b000, volts, temp};
  assign m_axis_tuser_o = stat;

  // a fault beat never carries a temperature
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (stat != STAT_OK) |-> temp == '0)
    else $error("fault beat with nonzero temperature");

  // an ok beat lies inside the rails: at or above the low rail, below the high rail
  a_ok_in_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (stat == STAT_OK) |->
      (volts >= VOLT_W'(RAIL_LOW_MV)) && (volts < VOLT_W'(RAIL_HIGH_MV)))
    else $error("ok beat outside rail window");

  // ok temperatures are never negative
  a_ok_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (stat == STAT_OK) |-> !temp[TEMP_W-1])
    else $error("negative temperature on ok beat");

endmodule

[hdl/ttl_front.sv]
module ttl_front import ttl_pkg::*; #(
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [CODE_W-1:0]   code_i,
  input  logic [VCC_W-1:0]    vcc_i,
  input  logic [SER_W-1:0]    series_i,
  output logic                vld_o,
  output side_t               side_o,
  output logic [NORM_FRAC:0]  ynum_o,
  output logic [KW-1:0]       knum_o,
  output logic [NORM_FRAC:0]  ycode_o,
  output logic [KW-1:0]       kcode_o
);

  localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int PROD_W = CODE_W + VCC_W;
  localparam logic [PROD_W:0]   RECIP   = (PROD_W+1)'((64'd1 << PROD_W) / ADC_FULL_SCALE);
  localparam logic [PROD_W-1:0] FS_P    = PROD_W'(ADC_FULL_SCALE);
  localparam logic [31:0]       RAIL_LO = 32'(RAIL_LOW_MV * ADC_FULL_SCALE);
  localparam logic [31:0]       RAIL_HI = 32'(RAIL_HIGH_MV * ADC_FULL_SCALE);
  localparam logic [31:0]       FS_32   = 32'(ADC_FULL_SCALE);

  logic [3:0]               vld_q;
  logic [CODE_W-1:0]        code1_q, code2_q;
  logic [PROD_W-1:0]        prod1_q, prod2_q, q0_q, volts3_q;
  logic                     rail2_q, rail3_q;
  logic [NUM_W-1:0]         num2_q, num3_q, code3_q;
  logic [KW-1:0]            knum3_q, kcode3_q;

  logic [2*PROD_W:0]        qm;
  logic                     rail_d;
  logic [FS_W-1:0]          nd;
  logic [PROD_W-1:0]        rem, volts_d;
  logic [NUM_W+NORM_FRAC-1:0] tn, tc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // reciprocal estimate is exact or one low
  assign qm = (2*PROD_W+1)'(prod1_q) * (2*PROD_W+1)'(RECIP);
  assign rail_d = ({9'd0, prod1_q} <= RAIL_LO) || ({9'd0, prod1_q} >= RAIL_HI) ||
                  ({22'd0, code1_q} >= FS_32) || (series_i == '0);
  assign nd = FS_W'(ADC_FULL_SCALE) - FS_W'(code1_q);

  assign rem     = prod2_q - PROD_W'(q0_q * FS_P);
  assign volts_d = (rem >= FS_P) ? q0_q + PROD_W'(1) : q0_q;

  assign tn = {num3_q, NORM_FRAC'(0)} >> knum3_q;
  assign tc = {code3_q, NORM_FRAC'(0)} >> kcode3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code1_q  <= code_i;
      prod1_q  <= PROD_W'(code_i) * PROD_W'(vcc_i);
      code2_q  <= code1_q;
      prod2_q  <= prod1_q;
      q0_q     <= qm[PROD_W +: PROD_W];
      rail2_q  <= rail_d;
      num2_q   <= NUM_W'(series_i * (SER_W+FS_W)'(nd));
      volts3_q <= volts_d;
      rail3_q  <= rail2_q;
      num3_q   <= num2_q;
      code3_q  <= NUM_W'(code2_q);
      knum3_q  <= msb_pos(num2_q);
      kcode3_q <= msb_pos(NUM_W'(code2_q));
      side_o.volts <= (volts3_q > PROD_W'(8191)) ? VOLT_W'(8191) : volts3_q[VOLT_W-1:0];
      side_o.rail  <= rail3_q;
      ynum_o   <= tn[NORM_FRAC:0];
      ycode_o  <= tc[NORM_FRAC:0];
      knum_o   <= knum3_q;
      kcode_o  <= kcode3_q;
    end
  end

  assign vld_o = vld_q[3];

endmodule

[hdl/ttl_log2.sv]
module ttl_log2 import ttl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  side_t              side_i,
  input  logic [NORM_FRAC:0] y_i  [2],
  input  logic [KW-1:0]      k_i  [2],
  output logic               vld_o,
  output side_t              side_o,
  output logic [LOG_W-1:0]   log_o [2]
);

  logic                 vld_s  [LOG_STEPS+1];
  side_t                side_s [LOG_STEPS+1];
  logic [NORM_FRAC:0]   y_s    [2][LOG_STEPS+1];
  logic [LOG_STEPS-1:0] fr_s   [2][LOG_STEPS+1];
  logic [KW-1:0]        k_s    [2][LOG_STEPS+1];

  assign vld_s[0]  = vld_i;
  assign side_s[0] = side_i;

  for (genvar l = 0; l < 2; l++) begin : g_in
    assign y_s[l][0]  = y_i[l];
    assign fr_s[l][0] = '0;
    assign k_s[l][0]  = k_i[l];
    assign log_o[l]   = {k_s[l][LOG_STEPS], fr_s[l][LOG_STEPS]};
  end

  // one squaring per stage, one fraction bit out of each
  for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j] <= 1'b0;
      end else if (en_i) begin
        vld_s[j] <= vld_s[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) side_s[j] <= side_s[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [2*NORM_FRAC+1:0] sq;
      logic [NORM_FRAC+1:0]   t;

      assign sq = (2*NORM_FRAC+2)'(y_s[l][j-1]) * (2*NORM_FRAC+2)'(y_s[l][j-1]);
      assign t  = sq[NORM_FRAC +: NORM_FRAC+2];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_s[l][j]  <= t[NORM_FRAC+1] ? t[NORM_FRAC+1:1] : t[NORM_FRAC:0];
          fr_s[l][j] <= {fr_s[l][j-1][LOG_STEPS-2:0], t[NORM_FRAC+1]};
          k_s[l][j]  <= k_s[l][j-1];
        end
      end
    end
  end

  assign vld_o  = vld_s[LOG_STEPS];
  assign side_o = side_s[LOG_STEPS];

endmodule

[hdl/ttl_poly.sv]
module ttl_poly import ttl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  side_t                 side_i,
  input  logic [LOG_W-1:0]      lognum_i,
  input  logic [LOG_W-1:0]      logcode_i,
  input  coef_t                 coef_i,
  output logic                  vld_o,
  output side_t                 side_o,
  output logic signed [D_W-1:0] den_o
);

  localparam int NST = 9;

  logic  vld_q  [NST];
  side_t side_q [NST];

  logic [LOG_W:0]          diff;
  logic [LOG_W-1:0]        mag1_q;
  logic                    neg1_q, neg2_q;
  logic [LOG_W+31:0]       mp2_q, rs;
  logic [L_W-2:0]          lmag;
  logic signed [L_W-1:0]   l3_q, l4_q, l5_q;
  logic signed [2*L_W-1:0] sq4_q;
  logic signed [P2_W-1:0]  pw2, pw2_5_q;
  logic signed [P2_W+L_W-1:0] m5_q;
  logic signed [P3_W-1:0]  pw [3];
  logic signed [CH_W+P3_W-1:0] hi6_q [3];
  logic signed [CL_W+P3_W:0]   lo6_q [3];
  logic signed [TERM_W-1:0]    t7_q  [3];
  logic signed [D_W-1:0]       s1_q, s2_q;
  logic [COEF_W-1:0]           cf [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  assign diff = {1'b0, lognum_i} - {1'b0, logcode_i};
  assign rs   = mp2_q + (LOG_W+32)'(64'd1 << 33);
  assign lmag = rs[34 +: L_W-1];
  assign pw2  = sq4_q[2*L_W-1:24];

  assign cf[0] = coef_i.b;
  assign cf[1] = coef_i.c;
  assign cf[2] = coef_i.d;
  assign pw[0] = P3_W'(l5_q);
  assign pw[1] = P3_W'(pw2_5_q);
  assign pw[2] = m5_q[P2_W+L_W-1:24];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < NST; i++) side_q[i] <= side_q[i-1];
      neg1_q  <= diff[LOG_W];
      mag1_q  <= diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
      neg2_q  <= neg1_q;
      mp2_q   <= (LOG_W+32)'(mag1_q) * (LOG_W+32)'(LN2_Q32);
      l3_q    <= neg2_q ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
      l4_q    <= l3_q;
      sq4_q   <= l3_q * l3_q;
      l5_q    <= l4_q;
      pw2_5_q <= pw2;
      m5_q    <= pw2 * l4_q;
      // coefficient split in halves: hi*pw + floor(lo*pw / 2^24)
      for (int k = 0; k < 3; k++) begin
        hi6_q[k] <= $signed(cf[k][COEF_W-1:CL_W]) * pw[k];
        lo6_q[k] <= $signed({1'b0, cf[k][CL_W-1:0]}) * pw[k];
        t7_q[k]  <= TERM_W'(hi6_q[k]) + TERM_W'($signed(lo6_q[k][CL_W+P3_W:24]));
      end
      s1_q  <= D_W'($signed(coef_i.a)) + D_W'(t7_q[0]);
      s2_q  <= D_W'(t7_q[1]) + D_W'(t7_q[2]);
      den_o <= s1_q + s2_q;
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule

[hdl/ttl_div.sv]
module ttl_div import ttl_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  side_t                 side_i,
  input  logic signed [D_W-1:0] den_i,
  output logic                  vld_o,
  output logic [TEMP_W-1:0]     temp_o,
  output logic [VOLT_W-1:0]     volts_o,
  output stat_e                 stat_o
);

  localparam int S    = COEF_FRAC_BITS + 8;
  localparam int QB   = TEMP_W - 1;
  localparam int CW   = (D_W - 1 + QB > S + 1) ? D_W - 1 + QB : S + 1;
  localparam logic signed [D_W-1:0] SAT_LIM = D_W'(1) <<< (S - 23);

  logic              vld_s  [QB+1];
  side_t             side_s [QB+1];
  logic              bad_s  [QB+1];
  logic              sat_s  [QB+1];
  logic [D_W-2:0]    d_s    [QB+1];
  logic [S:0]        rem_s  [QB+1];
  logic [QB-1:0]     q_s    [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
      vld_o    <= 1'b0;
    end else if (en_i) begin
      vld_s[0] <= vld_i;
      vld_o    <= vld_s[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_s[0] <= side_i;
      bad_s[0]  <= (den_i <= 0);
      sat_s[0]  <= (den_i <= SAT_LIM);
      d_s[0]    <= den_i[D_W-2:0];
      rem_s[0]  <= (S+1)'(1) << S;
      q_s[0]    <= '0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [CW-1:0] dsh;
    logic          take;

    assign dsh  = CW'(d_s[j-1]) << (QB - j);
    assign take = CW'(rem_s[j-1]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j] <= 1'b0;
      end else if (en_i) begin
        vld_s[j] <= vld_s[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[j] <= side_s[j-1];
        bad_s[j]  <= bad_s[j-1];
        sat_s[j]  <= sat_s[j-1];
        d_s[j]    <= d_s[j-1];
        rem_s[j]  <= take ? rem_s[j-1] - dsh[S:0] : rem_s[j-1];
        q_s[j]    <= {q_s[j-1][QB-2:0], take};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      volts_o <= side_s[QB].volts;
      priority if (side_s[QB].rail) begin
        stat_o <= STAT_RAIL;
        temp_o <= '0;
      end else if (bad_s[QB]) begin
        stat_o <= STAT_DEN;
        temp_o <= '0;
      end else if (sat_s[QB]) begin
        stat_o <= STAT_OK;
        temp_o <= {1'b0, {QB{1'b1}}};
      end else begin
        stat_o <= STAT_OK;
        temp_o <= {1'b0, q_s[QB]};
      end
    end
  end

endmodule
